// ===== rtl/erc_pkg.sv =====
// erc_pkg: shared types, constants and datapath step functions for the
// euler rotation recompose block. No dependencies; used by every rtl file.
package erc_pkg;

  localparam int QF              = 30;  // fraction bits of internal matrix entries
  localparam int QW              = 32;  // internal Q2.30 entry width
  localparam int ZW              = 34;  // angle in radians, 30 fraction bits
  localparam int CW              = 36;  // cordic x/y width with headroom
  localparam int SQW             = 63;  // square root remainder width
  localparam int MW              = 64;  // product and accumulator width
  localparam int STEPS           = 31;  // cordic and square root iterations
  localparam int PW_DEG          = 63;  // degree conversion product width
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int ROLL_W          = 31;
  localparam int PITCH_W         = 30;
  localparam int ORDER_W         = 3;

  localparam logic signed [ZW-1:0] PI_Q        = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q   = 34'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic signed [QW-1:0] ONE_Q       = 32'sd1073741824;
  localparam logic signed [MW-1:0] ROUND_Q     = 64'sd536870912;
  localparam logic [29:0]          DEG_SCALE   = 30'd961263669;
  localparam logic [31:0]          ROLL_LIM    = 32'd754974720;
  localparam logic [31:0]          PITCH_LIM   = 32'd377487360;

  // rotation order codes
  localparam logic [ORDER_W-1:0] ORD_XYZ = 3'd0;
  localparam logic [ORDER_W-1:0] ORD_YXZ = 3'd1;
  localparam logic [ORDER_W-1:0] ORD_YZX = 3'd2;
  localparam logic [ORDER_W-1:0] ORD_ZYX = 3'd3;
  localparam logic [ORDER_W-1:0] ORD_XZY = 3'd4;
  localparam logic [ORDER_W-1:0] ORD_ZXY = 3'd5;

  // axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    ang_t                 z;
  } cordic_t;

  typedef struct packed {
    cordic_t c;
    logic    zero_y;
    logic    neg_x;
  } vec_in_t;

  typedef struct packed {
    cordic_t c;
    logic    flip;
  } rot_in_t;

  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] c;
  } ord_t;

  localparam ang_t ATAN_TAB [STEPS] = '{
    34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6, 34'sh003FEAB76,
    34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55, 34'sh0003FFFEA, 34'sh0001FFFFD,
    34'sh0000FFFFF, 34'sh00007FFFF, 34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF,
    34'sh000007FFF, 34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
    34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F, 34'sh00000003F,
    34'sh00000001F, 34'sh00000000F, 34'sh000000008, 34'sh000000004, 34'sh000000002,
    34'sh000000001
  };

  // sign extend an entry to cordic width
  function automatic logic signed [CW-1:0] ext_cw(q_t v);
    return {{(CW-QW){v[QW-1]}}, v};
  endfunction

  // clamp to [-1, 1] in Q2.30
  function automatic q_t sat_one(logic signed [CW-1:0] v);
    q_t r;
    if (v > ext_cw(ONE_Q)) r = ONE_Q;
    else if (v < -ext_cw(ONE_Q)) r = -ONE_Q;
    else r = v[QW-1:0];
    return r;
  endfunction

  // quadrant fold ahead of vectoring
  function automatic vec_in_t vec_fold(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
    vec_in_t r;
    r.zero_y = (y == '0);
    r.neg_x  = x[CW-1];
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        r.c.x = y;
        r.c.y = -x;
        r.c.z = HALF_PI_Q;
      end else begin
        r.c.x = -y;
        r.c.y = x;
        r.c.z = -HALF_PI_Q;
      end
    end else begin
      r.c.x = x;
      r.c.y = y;
      r.c.z = '0;
    end
    return r;
  endfunction

  // one vectoring iteration
  function automatic cordic_t vec_step(cordic_t s, int i);
    cordic_t r;
    if (!s.y[CW-1]) begin
      r.x = s.x + (s.y >>> i);
      r.y = s.y - (s.x >>> i);
      r.z = s.z + ATAN_TAB[i];
    end else begin
      r.x = s.x - (s.y >>> i);
      r.y = s.y + (s.x >>> i);
      r.z = s.z - ATAN_TAB[i];
    end
    return r;
  endfunction

  // atan2 result including the zero vector case
  function automatic ang_t vec_result(vec_in_t s);
    ang_t z;
    if (s.zero_y) z = s.neg_x ? PI_Q : '0;
    else z = s.c.z;
    return z;
  endfunction

  // half-turn fold ahead of rotation
  function automatic rot_in_t rot_fold(ang_t a);
    rot_in_t r;
    r.c.x  = CORDIC_GAIN;
    r.c.y  = '0;
    r.c.z  = a;
    r.flip = 1'b0;
    if (a > HALF_PI_Q) begin
      r.c.z  = a - PI_Q;
      r.flip = 1'b1;
    end else if (a < -HALF_PI_Q) begin
      r.c.z  = a + PI_Q;
      r.flip = 1'b1;
    end
    return r;
  endfunction

  // one rotation iteration
  function automatic cordic_t rot_step(cordic_t s, int i);
    cordic_t r;
    if (!s.z[ZW-1]) begin
      r.x = s.x - (s.y >>> i);
      r.y = s.y + (s.x >>> i);
      r.z = s.z - ATAN_TAB[i];
    end else begin
      r.x = s.x + (s.y >>> i);
      r.y = s.y - (s.x >>> i);
      r.z = s.z + ATAN_TAB[i];
    end
    return r;
  endfunction

  // one digit of the floor square root, trial bit at position b
  function automatic sqrt_t sqrt_step(sqrt_t s, int b);
    logic [SQW-1:0] bit_v;
    logic [SQW-1:0] trial;
    sqrt_t          r;
    bit_v = SQW'(1) << b;
    trial = s.res + bit_v;
    if (s.n >= trial) begin
      r.n   = s.n - trial;
      r.res = (s.res >> 1) + bit_v;
    end else begin
      r.n   = s.n;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  // three term dot product, round half up and saturate to Q2.30
  function automatic q_t dot_round(logic signed [MW-1:0] p0, logic signed [MW-1:0] p1,
                                   logic signed [MW-1:0] p2);
    logic signed [MW-1:0] acc;
    logic signed [MW-1:0] sh;
    q_t                   r;
    acc = p0 + p1 + p2 + ROUND_Q;
    sh  = acc >>> QF;
    if (sh > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (sh < -64'sd2147483648) r = 32'sh80000000;
    else r = sh[QW-1:0];
    return r;
  endfunction

  // axis order for each order code, unused codes act as xyz
  function automatic ord_t order_sel(logic [ORDER_W-1:0] code);
    ord_t r;
    unique case (code)
      ORD_YXZ: r = '{a: AX_Y, b: AX_X, c: AX_Z};
      ORD_YZX: r = '{a: AX_Y, b: AX_Z, c: AX_X};
      ORD_ZYX: r = '{a: AX_Z, b: AX_Y, c: AX_X};
      ORD_XZY: r = '{a: AX_X, b: AX_Z, c: AX_Y};
      ORD_ZXY: r = '{a: AX_Z, b: AX_X, c: AX_Y};
      default: r = '{a: AX_X, b: AX_Y, c: AX_Z};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/erc_angles.sv =====
// erc_angles: pipelined roll, pitch and yaw extraction from a Q2.30 matrix
// (square root and cordic vectoring stages). Depends on erc_pkg.
module erc_angles import erc_pkg::*; #(
  parameter int PW = ORDER_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  q_t            m00_i,
  input  q_t            m10_i,
  input  q_t            m20_i,
  input  q_t            m21_i,
  input  q_t            m22_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output ang_t          roll_o,
  output ang_t          pitch_o,
  output ang_t          yaw_o,
  output logic [PW-1:0] pay_o
);

  // square, root digits, fold, vectoring steps, result
  localparam int NS = 2 * STEPS + 3;

  typedef struct packed {
    q_t ay;
    q_t ry;
    q_t rx;
    q_t yy;
    q_t yx;
  } src_t;

  logic [NS-1:0]  vld_q;
  logic [PW-1:0]  pay_q [NS];
  sqrt_t          sq_q  [STEPS+1];
  src_t           src_q [STEPS+1];
  vec_in_t        cv_q  [3][STEPS+1];
  ang_t           roll_q, pitch_q, yaw_q;

  q_t             a_clamp;
  logic [QW-2:0]  a_mag;
  logic [2*QW-3:0] a_sq;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // payload delay line
  always_ff @(posedge clk_i) begin
    if (en_i) pay_q[0] <= pay_i;
  end
  for (genvar k = 1; k < NS; k++) begin : g_pay
    always_ff @(posedge clk_i) begin
      if (en_i) pay_q[k] <= pay_q[k-1];
    end
  end

  // asin argument clamp and 1 - v*v
  assign a_clamp = (m20_i > ONE_Q) ? ONE_Q : ((m20_i < -ONE_Q) ? -ONE_Q : m20_i);
  assign a_mag   = a_clamp[QW-1] ? (QW-1)'(-a_clamp) : (QW-1)'(a_clamp);
  assign a_sq    = a_mag * a_mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0].n   <= (SQW'(1) << (2 * QF)) - SQW'(a_sq);
      sq_q[0].res <= '0;
      src_q[0]    <= '{ay: a_clamp, ry: m21_i, rx: m22_i, yy: m10_i, yx: m00_i};
    end
  end

  // square root, two bits of the radicand per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k]  <= sqrt_step(sq_q[k-1], 2 * QF - 2 * (k - 1));
        src_q[k] <= src_q[k-1];
      end
    end
  end

  // quadrant fold of the three vectors
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cv_q[0][0] <= vec_fold(ext_cw(src_q[STEPS].ay),
                             $signed({{(CW-QW){1'b0}}, sq_q[STEPS].res[QW-1:0]}));
      cv_q[1][0] <= vec_fold(ext_cw(src_q[STEPS].ry), ext_cw(src_q[STEPS].rx));
      cv_q[2][0] <= vec_fold(ext_cw(src_q[STEPS].yy), ext_cw(src_q[STEPS].yx));
    end
  end

  // vectoring, one iteration per stage
  for (genvar j = 0; j < 3; j++) begin : g_vec
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          cv_q[j][k].c      <= vec_step(cv_q[j][k-1].c, k - 1);
          cv_q[j][k].zero_y <= cv_q[j][k-1].zero_y;
          cv_q[j][k].neg_x  <= cv_q[j][k-1].neg_x;
        end
      end
    end
  end

  // final angles, pitch is minus the asin
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pitch_q <= -vec_result(cv_q[0][STEPS]);
      roll_q  <= vec_result(cv_q[1][STEPS]);
      yaw_q   <= vec_result(cv_q[2][STEPS]);
    end
  end

  assign valid_o = vld_q[NS-1];
  assign pay_o   = pay_q[NS-1];
  assign roll_o  = roll_q;
  assign pitch_o = pitch_q;
  assign yaw_o   = yaw_q;

endmodule

// ===== rtl/euler_rotation_recompose.sv =====
// euler_rotation_recompose: top level, matrix to euler angles, rebuilt product
// matrix and angles in degrees. Depends on erc_pkg and erc_angles.
//
// Usage:
//  - s_axis carries one 3x3 matrix per beat, m_axis one result per beat.
//  - cfg carries rotation_order; write it only while the block is empty.
//    cfg_ready_o is always high.
//  - From input beat to output beat the data passes two angle
//    extraction pipelines of 65 stages (31 square root digits and 31 cordic
//    vectoring steps each), a 33 stage sine/cosine cordic, 5 stages for the
//    two matrix products and 2 stages for the degree conversion.
//  - One beat per cycle sustained while m_axis_tready stays high; every stage carries a valid bit.
//  - When the receiver stalls with a result waiting, the whole pipeline
//    holds and s_axis_tready drops in the same cycle; nothing is lost.
//  - Reset clears the valid bits and sets rotation_order to xyz.
module euler_rotation_recompose import erc_pkg::*; #(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // in_r00 .. in_r22 from the lowest bit up, zero padded to bytes
  input  logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_r00 .. out_r22, roll_deg, pitch_deg, yaw_deg from the lowest bit up, zero padded
  output logic [((9*ENTRY_WIDTH+ROLL_W+PITCH_W+ROLL_W+7)/8)*8-1:0] m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ORDER_W-1:0]   cfg_data_i
);

  localparam int EW     = ENTRY_WIDTH;
  localparam int MAT_W  = 9 * EW;
  localparam int RES_W  = MAT_W + ROLL_W + PITCH_W + ROLL_W;
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
  localparam int SC_N   = STEPS + 2;

  typedef q_t mat_t [9];

  logic                en;
  logic [ORDER_W-1:0]  order_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORD_XYZ;
    end else if (cfg_valid_i) begin
      order_q <= cfg_data_i;
    end
  end

  // whole pipeline advances unless a result waits
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // input entries to Q2.30
  q_t in_m [9];
  for (genvar e = 0; e < 9; e++) begin : g_in
    if (EW >= QW) begin : g_wide
      assign in_m[e] = s_axis_tdata[e*EW + EW-1 -: QW];
    end else begin : g_narrow
      assign in_m[e] = {s_axis_tdata[e*EW +: EW], {(QW-EW){1'b0}}};
    end
  end

  // angles of the input matrix
  logic               a1_vld;
  ang_t               a1_ang [3];
  logic [ORDER_W-1:0] a1_ord;

  erc_angles #(.PW(ORDER_W)) u_ang_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .m00_i   (in_m[0]),
    .m10_i   (in_m[3]),
    .m20_i   (in_m[6]),
    .m21_i   (in_m[7]),
    .m22_i   (in_m[8]),
    .pay_i   (order_q),
    .valid_o (a1_vld),
    .roll_o  (a1_ang[0]),
    .pitch_o (a1_ang[1]),
    .yaw_o   (a1_ang[2]),
    .pay_o   (a1_ord)
  );

  // sine and cosine cordic: fold, iterations, sign restore and clamp
  logic [SC_N-1:0]    sc_vld_q;
  logic [ORDER_W-1:0] sc_ord_q [SC_N];
  cordic_t            sc_q     [3][STEPS+1];
  logic               sc_flip_q[3][STEPS+1];
  q_t                 sin_q    [3];
  q_t                 cos_q    [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= '0;
    end else if (en) begin
      sc_vld_q <= {sc_vld_q[SC_N-2:0], a1_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) sc_ord_q[0] <= a1_ord;
  end
  for (genvar k = 1; k < SC_N; k++) begin : g_sc_ord
    always_ff @(posedge clk_i) begin
      if (en) sc_ord_q[k] <= sc_ord_q[k-1];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_sc
    rot_in_t fold;
    assign fold = rot_fold(a1_ang[j]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sc_q[j][0]      <= fold.c;
        sc_flip_q[j][0] <= fold.flip;
      end
    end
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (en) begin
          sc_q[j][k]      <= rot_step(sc_q[j][k-1], k - 1);
          sc_flip_q[j][k] <= sc_flip_q[j][k-1];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sin_q[j] <= sat_one(sc_flip_q[j][STEPS] ? -sc_q[j][STEPS].y : sc_q[j][STEPS].y);
        cos_q[j] <= sat_one(sc_flip_q[j][STEPS] ? -sc_q[j][STEPS].x : sc_q[j][STEPS].x);
      end
    end
  end

  // axis rotations and order selection
  mat_t rot [3];
  ord_t ord;
  always_comb begin
    rot[AX_X] = '{ONE_Q, '0, '0, '0, cos_q[0], -sin_q[0], '0, sin_q[0], cos_q[0]};
    rot[AX_Y] = '{cos_q[1], '0, sin_q[1], '0, ONE_Q, '0, -sin_q[1], '0, cos_q[1]};
    rot[AX_Z] = '{cos_q[2], -sin_q[2], '0, sin_q[2], cos_q[2], '0, '0, '0, ONE_Q};
    ord       = order_sel(sc_ord_q[SC_N-1]);
  end

  // matrix products: select, multiply, sum, multiply, sum
  logic [4:0]           mm_vld_q;
  mat_t                 ma_q, mb_q, mc0_q, mc1_q, mc2_q, t_q, r_q;
  logic signed [MW-1:0] p1_q [27];
  logic signed [MW-1:0] p2_q [27];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_vld_q <= '0;
    end else if (en) begin
      mm_vld_q <= {mm_vld_q[3:0], sc_vld_q[SC_N-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q  <= rot[ord.a];
      mb_q  <= rot[ord.b];
      mc0_q <= rot[ord.c];
      mc1_q <= mc0_q;
      mc2_q <= mc1_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            p1_q[i*9+j*3+k] <= MW'(ma_q[i*3+k]) * MW'(mb_q[k*3+j]);
            p2_q[i*9+j*3+k] <= MW'(t_q[i*3+k]) * MW'(mc2_q[k*3+j]);
          end
          t_q[i*3+j] <= dot_round(p1_q[i*9+j*3], p1_q[i*9+j*3+1], p1_q[i*9+j*3+2]);
          r_q[i*3+j] <= dot_round(p2_q[i*9+j*3], p2_q[i*9+j*3+1], p2_q[i*9+j*3+2]);
        end
      end
    end
  end

  // product entries to the output width
  logic [MAT_W-1:0] r_pack;
  for (genvar e = 0; e < 9; e++) begin : g_out
    if (EW == QW) begin : g_same
      assign r_pack[e*EW +: EW] = r_q[e];
    end else if (EW > QW) begin : g_wide
      assign r_pack[e*EW +: EW] = {r_q[e], {(EW-QW){1'b0}}};
    end else begin : g_narrow
      localparam int SH = QW - EW;
      logic signed [QW:0] rnd;
      logic signed [QW:0] shr;
      assign rnd = $signed({r_q[e][QW-1], r_q[e]}) + $signed((QW+1)'(1) << (SH - 1));
      assign shr = rnd >>> SH;
      always_comb begin
        if (shr > $signed((QW+1)'((1 << (EW - 1)) - 1))) begin
          r_pack[e*EW +: EW] = {1'b0, {(EW-1){1'b1}}};
        end else if (shr < -$signed((QW+1)'(1 << (EW - 1)))) begin
          r_pack[e*EW +: EW] = {1'b1, {(EW-1){1'b0}}};
        end else begin
          r_pack[e*EW +: EW] = shr[EW-1:0];
        end
      end
    end
  end

  // angles of the product matrix
  logic             a2_vld;
  ang_t             a2_ang [3];
  logic [MAT_W-1:0] a2_pack;

  erc_angles #(.PW(MAT_W)) u_ang_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mm_vld_q[4]),
    .m00_i   (r_q[0]),
    .m10_i   (r_q[3]),
    .m20_i   (r_q[6]),
    .m21_i   (r_q[7]),
    .m22_i   (r_q[8]),
    .pay_i   (r_pack),
    .valid_o (a2_vld),
    .roll_o  (a2_ang[0]),
    .pitch_o (a2_ang[1]),
    .yaw_o   (a2_ang[2]),
    .pay_o   (a2_pack)
  );

  // radians to degrees: scale, then round, saturate and restore sign
  function automatic logic signed [ROLL_W-1:0] deg_fin(logic [PW_DEG-1:0] p, logic neg,
                                                       logic [31:0] lim);
    logic [PW_DEG:0] rsum;
    logic [31:0]     dm;
    logic [31:0]     ds;
    rsum = {1'b0, p} + (PW_DEG+1)'(64'h8000_0000);
    dm   = rsum[PW_DEG:32];
    if (dm > lim) dm = lim;
    ds   = neg ? -dm : dm;
    return ds[ROLL_W-1:0];
  endfunction

  logic [1:0]               dg_vld_q;
  logic [PW_DEG-1:0]        prod_q [3];
  logic                     neg_q  [3];
  logic [MAT_W-1:0]         dg_pack_q, res_pack_q;
  logic signed [ROLL_W-1:0] roll_q, yaw_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [ROLL_W-1:0] pitch_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dg_vld_q <= '0;
    end else if (en) begin
      dg_vld_q <= {dg_vld_q[0], a2_vld};
    end
  end

  assign pitch_full = deg_fin(prod_q[1], neg_q[1], PITCH_LIM);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        neg_q[j]  <= a2_ang[j][ZW-1];
        prod_q[j] <= (a2_ang[j][ZW-1] ? (ZW-1)'(-a2_ang[j]) : (ZW-1)'(a2_ang[j]))
                     * DEG_SCALE;
      end
      dg_pack_q  <= a2_pack;
      res_pack_q <= dg_pack_q;
      roll_q     <= deg_fin(prod_q[0], neg_q[0], ROLL_LIM);
      pitch_q    <= pitch_full[PITCH_W-1:0];
      yaw_q      <= deg_fin(prod_q[2], neg_q[2], ROLL_LIM);
    end
  end

  // result beat
  assign m_axis_tvalid           = dg_vld_q[1];
  assign m_axis_tdata[RES_W-1:0] = {yaw_q, pitch_q, roll_q, res_pack_q};
  if (OUT_W > RES_W) begin : g_pad
    assign m_axis_tdata[OUT_W-1:RES_W] = '0;
  end

  // a waiting result freezes the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while a result is stalled");

  // a result one stage from the end reaches the output when the pipe advances
  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dg_vld_q[0] |=> m_axis_tvalid)
    else $error("result lost between the last two stages");

  // pitch stays within a quarter turn
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pitch_q <= $signed(31'(PITCH_LIM)) &&
                       pitch_q >= -$signed(31'(PITCH_LIM))))
    else $error("pitch beyond ninety degrees");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for euler_rotation_recompose, matrix beats in, rebuilt
// matrix and angles out, checked against a bit-exact fixed-point predictor.
// Depends on erc_pkg and the euler_rotation_recompose rtl.
module tb import erc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW    = 32;
  localparam int IN_W  = ((9*EW+7)/8)*8;
  localparam int OUT_W = ((9*EW+ROLL_W+PITCH_W+ROLL_W+7)/8)*8;
  localparam int LATENCY = 170;

  typedef longint mat_t [9];
  typedef logic [EW-1:0] entries_t [9];

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // in_r00 .. in_r22 from the lowest bit up
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // out_r00 .. out_r22, roll_deg, pitch_deg, yaw_deg from the lowest bit up
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [ORDER_W-1:0] cfg_data_i;

  logic [OUT_W-1:0] results_due [$];
  logic [ORDER_W-1:0] order_reg;
  bit               calm;
  int               n_fail;

  euler_rotation_recompose u_top (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------- fixed-point predictor ----------------

  function automatic longint clampq(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan2_q(longint y, longint x);
    longint z, t, xn;
    z = 0;
    if (y == 0) return x < 0 ? longint'(PI_Q) : 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(HALF_PI_Q);
      end else begin
        t = x; x = -y; y = t; z = -longint'(HALF_PI_Q);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TAB[i]);
      end else begin
        xn = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
      end
      x = xn;
    end
    return z;
  endfunction

  function automatic void sincos_q(longint a, output longint s, output longint c);
    longint x, y, xn;
    bit flip;
    x = longint'(CORDIC_GAIN); y = 0; flip = 0;
    if (a > longint'(HALF_PI_Q)) begin
      a -= longint'(PI_Q); flip = 1;
    end else if (a < -longint'(HALF_PI_Q)) begin
      a += longint'(PI_Q); flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (a >= 0) begin
        xn = x - (y >>> i); y = y + (x >>> i); a -= longint'(ATAN_TAB[i]);
      end else begin
        xn = x + (y >>> i); y = y - (x >>> i); a += longint'(ATAN_TAB[i]);
      end
      x = xn;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = clampq(y, -(64'sd1 <<< QF), 64'sd1 <<< QF);
    c = clampq(x, -(64'sd1 <<< QF), 64'sd1 <<< QF);
  endfunction

  function automatic longint asin_q(longint v);
    longint unsigned n, res, b, mag;
    v = clampq(v, -(64'sd1 <<< QF), 64'sd1 <<< QF);
    mag = v < 0 ? -v : v;
    n = (64'd1 << 60) - mag * mag;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return atan2_q(v, longint'(res));
  endfunction

  function automatic mat_t mat_product(mat_t a, mat_t b);
    mat_t r;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i*3+k] * b[k*3+j];
        r[i*3+j] = clampq((acc + (64'sd1 <<< (QF-1))) >>> QF,
                          -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      end
    return r;
  endfunction

  function automatic longint unsigned to_degrees(longint rad, longint lim);
    longint unsigned mag;
    longint d;
    mag = rad < 0 ? -rad : rad;
    d = longint'((mag * 64'(DEG_SCALE) + (64'd1 << 31)) >> 32);
    if (rad < 0) d = -d;
    return clampq(d, -lim, lim);
  endfunction

  // axis rotations, index 0 roll about x, 1 pitch about y, 2 yaw about z
  function automatic void axis_rotations(longint roll, longint pitch, longint yaw,
                                         output mat_t rx, output mat_t ry, output mat_t rz);
    longint sr, cr, sp, cp, sy, cy, one;
    one = 64'sd1 <<< QF;
    sincos_q(roll, sr, cr);
    sincos_q(pitch, sp, cp);
    sincos_q(yaw, sy, cy);
    rx = '{one, 0, 0, 0, cr, -sr, 0, sr, cr};
    ry = '{cp, 0, sp, 0, one, 0, -sp, 0, cp};
    rz = '{cy, -sy, 0, sy, cy, 0, 0, 0, one};
  endfunction

  function automatic logic [OUT_W-1:0] recompose(entries_t e, logic [ORDER_W-1:0] ord);
    mat_t m, rx, ry, rz, p;
    longint roll, pitch, yaw;
    logic [OUT_W-1:0] r;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(e[i]));
    pitch = -asin_q(m[6]);
    roll  = atan2_q(m[7], m[8]);
    yaw   = atan2_q(m[3], m[0]);
    axis_rotations(roll, pitch, yaw, rx, ry, rz);
    case (ord)
      ORD_YXZ: p = mat_product(mat_product(ry, rx), rz);
      ORD_YZX: p = mat_product(mat_product(ry, rz), rx);
      ORD_ZYX: p = mat_product(mat_product(rz, ry), rx);
      ORD_XZY: p = mat_product(mat_product(rx, rz), ry);
      ORD_ZXY: p = mat_product(mat_product(rz, rx), ry);
      default: p = mat_product(mat_product(rx, ry), rz);
    endcase
    r = '0;
    for (int i = 0; i < 9; i++) r[i*EW +: EW] = p[i][EW-1:0];
    pitch = -asin_q(p[6]);
    roll  = atan2_q(p[7], p[8]);
    yaw   = atan2_q(p[3], p[0]);
    r[9*EW +: ROLL_W]                 = to_degrees(roll, longint'(ROLL_LIM));
    r[9*EW+ROLL_W +: PITCH_W]         = to_degrees(pitch, longint'(PITCH_LIM));
    r[9*EW+ROLL_W+PITCH_W +: ROLL_W]  = to_degrees(yaw, longint'(ROLL_LIM));
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(16);
  endfunction

  // matrix built from random angles, a true rotation with cordic error
  function automatic entries_t random_rotation();
    mat_t rx, ry, rz, p;
    entries_t e;
    axis_rotations(longint'($urandom_range(32'd3373259426)) - longint'(HALF_PI_Q) * 2,
                   longint'($urandom_range(32'd3373259426)) - longint'(HALF_PI_Q),
                   longint'($urandom_range(32'd3373259426)) - longint'(HALF_PI_Q) * 2,
                   rx, ry, rz);
    p = mat_product(mat_product(rz, ry), rx);
    for (int i = 0; i < 9; i++) e[i] = p[i][EW-1:0];
    return e;
  endfunction

  function automatic entries_t random_matrix();
    entries_t e;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) e = random_rotation();
    else
      for (int i = 0; i < 9; i++)
        e[i] = pick < 85 ? EW'($urandom_range(32'h8000_0000) - 32'h4000_0000) : $urandom;
    return e;
  endfunction

  task automatic send_matrix(entries_t e);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*EW +: EW] = e[i];
    repeat (draw_wait()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    results_due = {results_due, recompose(e, order_reg)};
  endtask

  // drain every result, let the pipe empty, then write the order register
  task automatic set_order(logic [ORDER_W-1:0] code);
    s_axis_tvalid <= 1'b0;
    wait (results_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_reg = code;
  endtask

  // ---------------- receiver and checker ----------------

  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      repeat (draw_wait()) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    string names [12];
    int lo [12];
    int w [12];
    names = '{"out_r00", "out_r01", "out_r02", "out_r10", "out_r11", "out_r12",
              "out_r20", "out_r21", "out_r22", "roll_deg", "pitch_deg", "yaw_deg"};
    for (int i = 0; i < 9; i++) begin
      lo[i] = i*EW; w[i] = EW;
    end
    lo[9] = 9*EW;  w[9] = ROLL_W;
    lo[10] = 9*EW+ROLL_W; w[10] = PITCH_W;
    lo[11] = 9*EW+ROLL_W+PITCH_W; w[11] = ROLL_W;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        want = results_due.pop_front();
        for (int f = 0; f < 12; f++)
          if (((want ^ m_axis_tdata) >> lo[f]) & ((OUT_W'(1) << w[f]) - 1)) begin
            $error("%s expected %0h got %0h", names[f],
                   (want >> lo[f]) & ((OUT_W'(1) << w[f]) - 1),
                   (m_axis_tdata >> lo[f]) & ((OUT_W'(1) << w[f]) - 1));
            n_fail++;
          end
      end
    end
  end

  // ---------------- main sequence ----------------

  typedef struct {
    logic [ORDER_W-1:0] ord;
    entries_t           m;
  } row_t;

  initial begin
    row_t rows [16];
    entries_t e;
    logic [ORDER_W-1:0] phase_order [8];
    int budget;
    n_fail = 0;
    calm = 1'b0;
    order_reg = ORD_XYZ;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = ORD_XYZ;

    // identity, zero, extremes, clamped asin, zero vector with negative x, half turns, unused codes
    rows[0]  = '{ORD_XYZ, '{32'h40000000, 0, 0, 0, 32'h40000000, 0, 0, 0, 32'h40000000}};
    rows[1]  = '{ORD_XYZ, '{0, 0, 0, 0, 0, 0, 0, 0, 0}};
    rows[2]  = '{ORD_XYZ, '{default: 32'h7FFFFFFF}};
    rows[3]  = '{ORD_XYZ, '{default: 32'h80000000}};
    rows[4]  = '{ORD_YXZ, '{32'h40000000, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 32'h40000000}};
    rows[5]  = '{ORD_YXZ, '{32'h40000000, 0, 0, 0, 0, 0, 32'h80000000, 0, 32'h40000000}};
    rows[6]  = '{ORD_YZX, '{32'hC0000000, 0, 0, 0, 32'h40000000, 0, 0, 0, 32'h40000000}};
    rows[7]  = '{ORD_YZX, '{32'h40000000, 0, 0, 0, 32'hC0000000, 0, 0, 0, 32'hC0000000}};
    rows[8]  = '{ORD_ZYX, '{0, 0, 32'h40000000, 0, 32'h40000000, 0, 32'hC0000000, 0, 0}};
    rows[9]  = '{ORD_ZYX, '{0, 0, 32'hC0000000, 0, 32'h40000000, 0, 32'h40000000, 0, 0}};
    rows[10] = '{ORD_XZY, '{0, 32'hC0000000, 0, 32'h40000000, 0, 0, 0, 0, 32'h40000000}};
    rows[11] = '{ORD_XZY, '{32'hC0000000, 0, 0, 0, 32'hC0000000, 0, 0, 0, 32'h40000000}};
    rows[12] = '{ORD_ZXY, '{32'h2D413CCD, 32'hD2BEC333, 0, 32'h2D413CCD, 32'h2D413CCD, 0,
                            0, 0, 32'h40000000}};
    rows[13] = '{ORD_ZXY, '{32'h40000001, 0, 0, 0, 32'h40000000, 32'h3FFFFFFF, 32'h40000001,
                            32'hBFFFFFFF, 32'h40000000}};
    rows[14] = '{3'd6,    '{32'h40000000, 0, 0, 32'h1, 32'h40000000, 0, 0, 32'h1, 32'hC0000000}};
    rows[15] = '{3'd7,    '{32'h40000000, 0, 0, 0, 32'h40000000, 0, 32'h3FFFFFFF, 0,
                            32'h40000000}};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, predictor checked
    foreach (rows[i]) begin
      if (rows[i].ord != order_reg) set_order(rows[i].ord);
      send_matrix(rows[i].m);
    end

    // random phases across every order code, unused codes 6 and 7 included
    phase_order = '{ORD_ZXY, ORD_XYZ, ORD_YXZ, 3'd7, ORD_YZX, ORD_ZYX, 3'd6, ORD_XZY};
    foreach (phase_order[p]) begin
      set_order(phase_order[p]);
      budget = 242;
      while (budget > 0) begin
        if ($urandom_range(39) == 0) calm = ~calm;
        e = random_matrix();
        send_matrix(e);
        budget--;
      end
      calm = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    wait (results_due.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_fail == 0 && results_due.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== euler_rotation_recompose.f =====
rtl/erc_pkg.sv
rtl/erc_angles.sv
rtl/euler_rotation_recompose.sv
sim/tb.sv
